/* src/shuffle_order_navigator_assert.svh */
// Assertion macros for the shuffle order navigator.
`ifndef SHUFFLE_ORDER_NAVIGATOR_ASSERT_SVH
`define SHUFFLE_ORDER_NAVIGATOR_ASSERT_SVH
`ifndef ASSERT_OFF
`define SON_ASSERT_IMPLY(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("shuffle order navigator check failed");
`define SON_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("shuffle order navigator check failed");
`else
`define SON_ASSERT_IMPLY(label, clk, rst, cond, prop)
`define SON_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif
`endif

/* src/son_pkg.sv */
package son_pkg;
   localparam int OP_W    = 2;
   localparam int SEED_W  = 32;
   localparam int TRACK_W = 13;
   localparam int COUNT_W = 14;

   typedef logic [OP_W-1:0] op_type;

   localparam op_type OP_RESTART = 2'd0;
   localparam op_type OP_PREV    = 2'd1;
   localparam op_type OP_CURRENT = 2'd2;
   localparam op_type OP_NEXT    = 2'd3;
endpackage

/* src/son_req_if.sv */
interface son_req_if;
   logic                         valid;
   logic                         ready;
   son_pkg::op_type              op;
   logic [son_pkg::SEED_W-1:0]   seed_value;
   logic [son_pkg::SEED_W-1:0]   tick_random;

   modport source (output valid, output op, output seed_value, output tick_random,
                   input ready);
   modport sink (input valid, input op, input seed_value, input tick_random,
                 output ready);
endinterface

/* src/son_rsp_if.sv */
interface son_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [son_pkg::TRACK_W-1:0]  track;
   logic                         reshuffled;

   modport source (output valid, output track, output reshuffled, input ready);
   modport sink (input valid, input track, input reshuffled, output ready);
endinterface

/* src/son_divider.sv */
module son_divider #(
   parameter int DIVISOR_W = 14
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [son_pkg::SEED_W-1:0]  dividend,
   input  logic [DIVISOR_W-1:0]        divisor,
   output logic                        done,
   output logic [DIVISOR_W-1:0]        remainder
);
   localparam int CNT_W = $clog2(son_pkg::SEED_W);

   logic                        busy_ff;
   logic                        done_ff;
   logic [CNT_W-1:0]            cnt_ff;
   logic [DIVISOR_W-1:0]        rem_ff;
   logic [DIVISOR_W-1:0]        dsr_ff;
   logic [son_pkg::SEED_W-1:0]  dvd_ff;
   logic [DIVISOR_W:0]          trial;
   logic [DIVISOR_W:0]          rem_in;

   // restoring step: one quotient bit per cycle, keep only the remainder
   always_comb begin
      trial = {rem_ff, dvd_ff[son_pkg::SEED_W-1]};
      if (trial >= {1'b0, dsr_ff}) begin
         rem_in = trial - {1'b0, dsr_ff};
      end else begin
         rem_in = trial;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(son_pkg::SEED_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         dsr_ff <= divisor;
         dvd_ff <= dividend;
      end else if (busy_ff) begin
         rem_ff <= rem_in[DIVISOR_W-1:0];
         dvd_ff <= {dvd_ff[son_pkg::SEED_W-2:0], 1'b0};
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;
endmodule

/* src/shuffle_order_navigator.sv */
// Shuffle order navigator. Commands arrive one word at a time and each gives one
// result word. After reset the order memory is swept to zero, one entry a cycle,
// and no command is taken during the sweep. Previous, next from history and
// current each need one memory read. A next that draws a new track runs the
// 32-step remainder unit and then the read-swap-write of two entries. In a restart
// or reshuffle the remainder unit picks the first track, then the identity order,
// with that track swapped into entry zero, is written back one entry a cycle
// through the single memory port; a restart with an explicit first track skips
// the remainder unit.
`include "shuffle_order_navigator_assert.svh"
module shuffle_order_navigator #(
   parameter int MAX_TRACKS = 8192
) (
   input  logic          clock,
   input  logic          reset,
   son_req_if.sink       req_ch,
   son_rsp_if.source     rsp_ch,
   input  logic          csr_psel,
   input  logic          csr_penable,
   input  logic          csr_pwrite,
   input  logic [2:0]    csr_paddr,
   input  logic [31:0]   csr_pwdata,
   output logic [31:0]   csr_prdata,
   output logic          csr_pready
);
   localparam int AW = $clog2(MAX_TRACKS);
   localparam int CW = $clog2(MAX_TRACKS + 1);

   localparam logic [3:0] S_CLEAR   = 4'd0;
   localparam logic [3:0] S_IDLE    = 4'd1;
   localparam logic [3:0] S_REB     = 4'd2;
   localparam logic [3:0] S_REB_RD1 = 4'd3;
   localparam logic [3:0] S_REB_DIV = 4'd4;
   localparam logic [3:0] S_REB_WR  = 4'd5;
   localparam logic [3:0] S_DR_DIV  = 4'd6;
   localparam logic [3:0] S_DR_RD0  = 4'd7;
   localparam logic [3:0] S_DR_RD1  = 4'd8;
   localparam logic [3:0] S_DR_WR0  = 4'd9;
   localparam logic [3:0] S_DR_WR1  = 4'd10;
   localparam logic [3:0] S_RD_OUT  = 4'd11;
   localparam logic [3:0] S_DONE    = 4'd12;

   logic [AW-1:0] order_mem [MAX_TRACKS];
   logic          mem_we;
   logic [AW-1:0] mem_addr;
   logic [AW-1:0] mem_wd;
   logic [AW-1:0] mem_rd_ff;

   logic [3:0]    state_ff;
   logic [son_pkg::COUNT_W-1:0] track_count_ff;
   logic [CW-1:0] drawn_ff;
   logic [AW-1:0] hp_ff;
   logic          swapped_ff;
   logic [CW-1:0] list_ff;
   logic [CW-1:0] num_ff;
   logic          random_ff;
   logic [AW-1:0] pick_ff;
   logic [AW-1:0] first_ff;
   logic [AW-1:0] idx_ff;
   logic [AW-1:0] pos_ff;
   logic [AW-1:0] tmp_ff;
   logic [son_pkg::SEED_W-1:0] tick_ff;
   logic [AW-1:0] res_trk_ff;
   logic          res_resh_ff;
   logic          out_valid_ff;
   logic [AW-1:0] out_trk_ff;
   logic          out_resh_ff;

   logic          accept;
   son_pkg::op_type real_op;
   logic [CW-1:0] clamp_num;
   logic          div_start;
   logic          div_done;
   logic [son_pkg::SEED_W-1:0] div_dividend;
   logic [CW-1:0] div_divisor;
   logic [CW-1:0] div_rem;
   logic [AW-1:0] p0;
   logic [AW-1:0] p1;
   logic [AW-1:0] p2;
   logic [AW-1:0] pick_rand;
   logic          draw_go;
   logic          out_free;
   logic [31:0]   trk32;

   assign accept   = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE);
   assign out_free = !out_valid_ff || rsp_ch.ready;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == 1'b0) ? 32'(track_count_ff) : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         track_count_ff <= son_pkg::COUNT_W'(1);
      end else if (csr_psel && csr_penable && csr_pwrite && (csr_paddr[2] == 1'b0)) begin
         track_count_ff <= csr_pwdata[son_pkg::COUNT_W-1:0];
      end
   end

   always_comb begin
      if (track_count_ff == '0) begin
         clamp_num = CW'(1);
      end else if (32'(track_count_ff) > 32'(MAX_TRACKS)) begin
         clamp_num = CW'(MAX_TRACKS);
      end else begin
         clamp_num = CW'(track_count_ff);
      end
   end

   assign real_op = swapped_ff ? ((req_ch.op == son_pkg::OP_PREV) ? son_pkg::OP_NEXT
                                                                   : son_pkg::OP_PREV)
                               : req_ch.op;

   // draw a new track when the next is neither past the end nor in history
   assign draw_go = (drawn_ff < list_ff) &&
                    !((drawn_ff != '0) && ((CW'(hp_ff) + CW'(1)) < drawn_ff));

   assign div_start = (accept && (req_ch.op != son_pkg::OP_RESTART) &&
                       (req_ch.op != son_pkg::OP_CURRENT) &&
                       (real_op == son_pkg::OP_NEXT) && draw_go) ||
                      (state_ff == S_REB_RD1);
   assign div_dividend = (state_ff == S_IDLE) ? req_ch.seed_value : tick_ff;
   assign div_divisor  = (state_ff == S_IDLE) ? (list_ff - drawn_ff) : num_ff;

   son_divider #(.DIVISOR_W(CW)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .remainder (div_rem)
   );

   // step off the old first and old last (held in mem_rd_ff), wrapping at count
   always_comb begin
      p0 = div_rem[AW-1:0];
      if (p0 == first_ff || p0 == mem_rd_ff) begin
         p1 = ((CW'(p0) + CW'(1)) == num_ff) ? '0 : p0 + 1'b1;
      end else begin
         p1 = p0;
      end
      if (p1 == first_ff || p1 == mem_rd_ff) begin
         p2 = ((CW'(p1) + CW'(1)) == num_ff) ? '0 : p1 + 1'b1;
      end else begin
         p2 = p1;
      end
      if (num_ff == CW'(1)) begin
         pick_rand = '0;
      end else if (num_ff == CW'(2)) begin
         pick_rand = (mem_rd_ff == '0) ? AW'(1) : '0;
      end else begin
         pick_rand = p2;
      end
   end

   always_comb begin
      mem_we   = 1'b0;
      mem_addr = '0;
      mem_wd   = '0;
      case (state_ff)
         S_CLEAR: begin
            mem_we   = 1'b1;
            mem_addr = idx_ff;
         end
         S_IDLE: begin
            if (req_ch.op == son_pkg::OP_CURRENT) begin
               mem_addr = (drawn_ff != '0) ? AW'(drawn_ff - CW'(1)) : '0;
            end else if (real_op == son_pkg::OP_PREV) begin
               mem_addr = hp_ff - 1'b1;
            end else begin
               mem_addr = hp_ff + 1'b1;
            end
         end
         S_REB_RD1, S_REB_DIV: begin
            mem_addr = AW'(num_ff - CW'(1));
         end
         S_REB_WR: begin
            mem_we   = 1'b1;
            mem_addr = idx_ff;
            if (idx_ff == '0) begin
               mem_wd = pick_ff;
            end else if (idx_ff == pick_ff) begin
               mem_wd = '0;
            end else begin
               mem_wd = idx_ff;
            end
         end
         S_DR_RD0: begin
            mem_addr = pos_ff;
         end
         S_DR_RD1: begin
            mem_addr = AW'(drawn_ff);
         end
         S_DR_WR0: begin
            mem_we   = 1'b1;
            mem_addr = pos_ff;
            mem_wd   = mem_rd_ff;
         end
         S_DR_WR1: begin
            mem_we   = 1'b1;
            mem_addr = AW'(drawn_ff);
            mem_wd   = tmp_ff;
         end
         default: begin
            mem_addr = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         order_mem[mem_addr] <= mem_wd;
      end
      mem_rd_ff <= order_mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         idx_ff       <= '0;
         drawn_ff     <= '0;
         hp_ff        <= '0;
         swapped_ff   <= 1'b0;
         list_ff      <= CW'(1);
      end else begin
         case (state_ff)
            S_CLEAR: begin
               idx_ff <= idx_ff + 1'b1;
               if (idx_ff == AW'(MAX_TRACKS - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (accept) begin
                  tick_ff <= req_ch.tick_random;
                  idx_ff  <= '0;
                  if (req_ch.op == son_pkg::OP_RESTART) begin
                     swapped_ff <= 1'b0;
                     num_ff     <= clamp_num;
                     random_ff  <= req_ch.seed_value >= 32'(clamp_num);
                     pick_ff    <= req_ch.seed_value[AW-1:0];
                     state_ff   <= S_REB;
                  end else if (req_ch.op == son_pkg::OP_CURRENT) begin
                     state_ff <= S_RD_OUT;
                  end else if (real_op == son_pkg::OP_PREV) begin
                     if (hp_ff == '0) begin
                        swapped_ff <= !swapped_ff;
                        num_ff     <= list_ff;
                        random_ff  <= 1'b1;
                        state_ff   <= S_REB;
                     end else begin
                        hp_ff    <= hp_ff - 1'b1;
                        state_ff <= S_RD_OUT;
                     end
                  end else if (drawn_ff >= list_ff) begin
                     num_ff    <= list_ff;
                     random_ff <= 1'b1;
                     state_ff  <= S_REB;
                  end else if (!draw_go) begin
                     hp_ff    <= hp_ff + 1'b1;
                     state_ff <= S_RD_OUT;
                  end else begin
                     state_ff <= S_DR_DIV;
                  end
               end
            end
            S_REB: begin
               state_ff <= random_ff ? S_REB_RD1 : S_REB_WR;
            end
            S_REB_RD1: begin
               first_ff <= mem_rd_ff;
               state_ff <= S_REB_DIV;
            end
            S_REB_DIV: begin
               if (div_done) begin
                  pick_ff  <= pick_rand;
                  state_ff <= S_REB_WR;
               end
            end
            S_REB_WR: begin
               idx_ff <= idx_ff + 1'b1;
               if (CW'(idx_ff) == num_ff - CW'(1)) begin
                  drawn_ff    <= CW'(1);
                  hp_ff       <= '0;
                  list_ff     <= num_ff;
                  res_trk_ff  <= pick_ff;
                  res_resh_ff <= 1'b1;
                  state_ff    <= S_DONE;
               end
            end
            S_DR_DIV: begin
               if (div_done) begin
                  pos_ff   <= AW'(drawn_ff + div_rem);
                  state_ff <= S_DR_RD0;
               end
            end
            S_DR_RD0: begin
               state_ff <= S_DR_RD1;
            end
            S_DR_RD1: begin
               tmp_ff   <= mem_rd_ff;
               state_ff <= S_DR_WR0;
            end
            S_DR_WR0: begin
               state_ff <= S_DR_WR1;
            end
            S_DR_WR1: begin
               drawn_ff    <= drawn_ff + CW'(1);
               hp_ff       <= AW'(drawn_ff);
               res_trk_ff  <= tmp_ff;
               res_resh_ff <= 1'b0;
               state_ff    <= S_DONE;
            end
            S_RD_OUT: begin
               res_trk_ff  <= mem_rd_ff;
               res_resh_ff <= 1'b0;
               state_ff    <= S_DONE;
            end
            S_DONE: begin
               // hold the result until the output register frees up
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (state_ff == S_DONE && out_free) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.valid && rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_DONE && out_free) begin
         out_trk_ff  <= res_trk_ff;
         out_resh_ff <= res_resh_ff;
      end
   end

   assign trk32             = 32'(out_trk_ff);
   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.track      = trk32[son_pkg::TRACK_W-1:0];
   assign rsp_ch.reshuffled = out_resh_ff;

   `SON_ASSERT_IMPLY(a_drawn_bound, clock, reset, 1'b1, drawn_ff <= list_ff)
   `SON_ASSERT_IMPLY(a_hist_bound, clock, reset, drawn_ff != '0, CW'(hp_ff) < drawn_ff)
   `SON_ASSERT_IMPLY(a_div_done_state, clock, reset, div_done,
                     state_ff == S_REB_DIV || state_ff == S_DR_DIV)
   `SON_ASSERT_NEXT(a_restart_rebuilds, clock, reset,
                    accept && req_ch.op == son_pkg::OP_RESTART, state_ff == S_REB)
endmodule
